FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the tone sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define PTS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define PTS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/pts_pkg.sv
// ----------------------------------------------------------------------------
// Tone sequencer package
// Codes, payload layouts, constant tables and the controller/datapath link.
// ----------------------------------------------------------------------------
package pts_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_STEP_COUNT        = 2'd0,
    REG_OCTAVE_SHIFT      = 2'd1,
    REG_FRAMES_PER_BEAT   = 2'd2,
    REG_SAMPLES_PER_FRAME = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_X2,
    ST_Q,
    ST_W,
    ST_Y,
    ST_MIX_ABS,
    ST_MIX_DIV,
    ST_EMIT
  } state_t;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned STEP_CNT_W  = 5;
  localparam int unsigned SHIFT_W     = 3;
  localparam int unsigned FPB_W       = 8;
  localparam int unsigned SPF_W       = 12;

  localparam logic [STEP_CNT_W-1:0] STEP_COUNT_RST = 5'd0;
  localparam logic [SHIFT_W-1:0]    SHIFT_RST      = 3'd0;
  localparam logic [FPB_W-1:0]      FPB_RST        = 8'd8;
  localparam logic [SPF_W-1:0]      SPF_RST        = 12'd320;

  localparam int unsigned STEP_IN_W   = 4;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned NOTE_FIELDS = 4;
  localparam int unsigned VOICE_IDX_W = 3;
  localparam int unsigned ROW_W       = COUNT_W + NOTE_FIELDS * NOTE_W;
  localparam int unsigned IN_DATA_W   = 40;

  localparam int unsigned SAMPLE_W    = 15;
  localparam int unsigned STEP_OUT_W  = 4;
  localparam int unsigned OUT_DATA_W  = 24;
  localparam int unsigned OUT_PAD_W   = OUT_DATA_W - SAMPLE_W - STEP_OUT_W;

  localparam longint unsigned SAMPLE_RATE  = 16000;
  localparam int unsigned     SINE_ENTRIES = 1024;
  localparam int unsigned     SINE_BITS    = $clog2(SINE_ENTRIES);

  // Frequencies of MIDI notes 60 to 71 in Hz, scaled by 2^16.
  localparam logic [24:0] PITCH_ROM [12] = '{
    25'd17145893, 25'd18165441, 25'd19245614, 25'd20390018,
    25'd21602472, 25'd22887021, 25'd24247955, 25'd25689813,
    25'd27217409, 25'd28835840, 25'd30550508, 25'd32367136
  };

  // Rounded-up 2^24 / count; exact floor division for quotients below 2^17.
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [24:0] RECIP [8] = '{
    25'd0,       25'd16777216, 25'd8388608, 25'd5592406,
    25'd4194304, 25'd3355444,  25'd2796203, 25'd2396746
  };

  typedef struct packed {
    logic                   load;
    logic                   start;
    logic                   stop;
    logic                   tick_begin;
    logic                   voice_setup;
    logic                   step_x2;
    logic                   step_q;
    logic                   step_w;
    logic                   voice_finish;
    logic                   mix_abs;
    logic                   mix_div;
    logic                   emit;
    logic [VOICE_IDX_W-1:0] voice;
  } cmd_t;

  typedef struct packed {
    logic               active;
    logic [COUNT_W-1:0] sounding;
  } status_t;

endpackage

FILE: design/pts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pts_ctrl.sv
// ----------------------------------------------------------------------------
// Tone sequencer controller
// Steps playing ticks through voice setup, sine polynomial, mix and output.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [pts_pkg::OP_W-1:0]     in_op,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  pts_pkg::status_t             status,
  output pts_pkg::cmd_t                cmd
);

  pts_pkg::state_t                      state, state_next;
  logic [pts_pkg::VOICE_IDX_W-1:0]      voice, voice_next;
  logic                                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pts_pkg::ST_IDLE;
      voice     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      voice     <= voice_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    voice_next = voice;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.voice  = voice;
    case (state)
      pts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (pts_pkg::op_t'(in_op))
            pts_pkg::OP_LOAD:  cmd.load  = 1'b1;
            pts_pkg::OP_START: cmd.start = 1'b1;
            pts_pkg::OP_STOP:  cmd.stop  = 1'b1;
            pts_pkg::OP_TICK: begin
              if (status.active) begin
                cmd.tick_begin = 1'b1;
                voice_next     = '0;
                state_next     = pts_pkg::ST_SETUP;
              end else begin
                state_next = pts_pkg::ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      pts_pkg::ST_SETUP: begin
        if (voice < status.sounding) begin
          cmd.voice_setup = 1'b1;
          state_next      = pts_pkg::ST_X2;
        end else begin
          state_next = pts_pkg::ST_MIX_ABS;
        end
      end
      pts_pkg::ST_X2: begin
        cmd.step_x2 = 1'b1;
        state_next  = pts_pkg::ST_Q;
      end
      pts_pkg::ST_Q: begin
        cmd.step_q = 1'b1;
        state_next = pts_pkg::ST_W;
      end
      pts_pkg::ST_W: begin
        cmd.step_w = 1'b1;
        state_next = pts_pkg::ST_Y;
      end
      pts_pkg::ST_Y: begin
        cmd.voice_finish = 1'b1;
        voice_next       = voice + 1'b1;
        state_next       = pts_pkg::ST_SETUP;
      end
      pts_pkg::ST_MIX_ABS: begin
        cmd.mix_abs = 1'b1;
        state_next  = pts_pkg::ST_MIX_DIV;
      end
      pts_pkg::ST_MIX_DIV: begin
        cmd.mix_div = 1'b1;
        state_next  = pts_pkg::ST_EMIT;
      end
      pts_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = pts_pkg::ST_IDLE;
        end
      end
      default: state_next = pts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: design/pts_datapath.sv
// ----------------------------------------------------------------------------
// Tone sequencer datapath
// Configuration, chord memory, voice phases, sine polynomial, mixer and counters.
// ----------------------------------------------------------------------------
module pts_datapath #(
  parameter int unsigned MAX_STEPS  = 16,
  parameter int unsigned VOICES     = 4,
  parameter int unsigned PHASE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [pts_pkg::IN_DATA_W-1:0]      in_data,
  input  pts_pkg::cmd_t                      cmd,
  output pts_pkg::status_t                   status,
  output logic [pts_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                               out_last
);

  localparam int unsigned STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned NV     = (VOICES < pts_pkg::NOTE_FIELDS) ? VOICES
                                                                   : pts_pkg::NOTE_FIELDS;
  localparam int unsigned VW     = (NV > 1) ? $clog2(NV) : 1;
  localparam int unsigned TW     = PHASE_BITS + 13;
  localparam int unsigned SW     = TW + 11;

  // Phase increment of each pitch class in its lowest octave, before scaling.
  localparam logic [TW-1:0] STEP_TABLE [16] = '{
    TW'((64'(pts_pkg::PITCH_ROM[0])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[1])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[2])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[3])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[4])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[5])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[6])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[7])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[8])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[9])  << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[10]) << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'((64'(pts_pkg::PITCH_ROM[11]) << PHASE_BITS) / pts_pkg::SAMPLE_RATE),
    TW'(0), TW'(0), TW'(0), TW'(0)
  };

  // Configuration registers.
  logic        [pts_pkg::STEP_CNT_W-1:0] step_count;
  logic signed [pts_pkg::SHIFT_W-1:0]    octave_shift;
  logic        [pts_pkg::FPB_W-1:0]      frames_per_beat;
  logic        [pts_pkg::SPF_W-1:0]      samples_per_frame;

  // Playback state.
  logic                                  running;
  logic [pts_pkg::SPF_W-1:0]             sample_in_frame;
  logic [pts_pkg::FPB_W-1:0]             frame_in_beat;
  logic [STEP_W-1:0]                     step_now;
  logic [PHASE_BITS-1:0]                 phase [NV];

  // Chord memory.
  logic [pts_pkg::STEP_IN_W-1:0]         in_step;
  logic                                  ram_we;
  logic [pts_pkg::ROW_W-1:0]             row;
  logic [pts_pkg::COUNT_W-1:0]           row_count;
  logic [pts_pkg::NOTE_W-1:0]            note_sel;

  // Per-voice working registers.
  logic [PHASE_BITS-1:0]                 phase_sel;
  logic signed [8:0]                     shift12;
  logic signed [8:0]                     note_sum;
  logic [pts_pkg::NOTE_W-1:0]            note_clamped;
  logic [14:0]                           oct_prod;
  logic [3:0]                            oct_val;
  logic [3:0]                            rem_val;
  logic [pts_pkg::SINE_BITS-1:0]         sine_idx;
  logic [15:0]                           turn;
  logic [14:0]                           x_val;
  logic [14:0]                           x;
  logic [1:0]                            quad;
  logic [3:0]                            oct;
  logic [3:0]                            rem;
  logic [29:0]                           sq;
  logic [SW-1:0]                         inc_shifted;
  logic [SW-1:0]                         inc_sum;
  logic [14:0]                           x2;
  logic [PHASE_BITS-1:0]                 inc;
  logic [25:0]                           q_prod;
  logic [13:0]                           q;
  logic [28:0]                           w_prod;
  logic [14:0]                           w;
  logic [29:0]                           y_prod;
  logic [15:0]                           y;
  logic [16:0]                           two_y;
  logic signed [18:0]                    sine_ext;
  logic signed [18:0]                    sum;

  // Mixer.
  logic [17:0]                           abs_sum;
  logic                                  neg;
  logic [32:0]                           mag_prod;
  logic [41:0]                           quot_prod;
  logic [17:0]                           quot;
  logic [17:0]                           quot_signed;

  // Counters and output.
  logic [pts_pkg::STEP_CNT_W-1:0]        eff;
  logic                                  active;
  logic [pts_pkg::SPF_W-1:0]             spf_inc;
  logic [pts_pkg::FPB_W-1:0]             fpb_inc;
  logic [STEP_W:0]                       step_inc;
  logic                                  frame_wrap;
  logic [pts_pkg::SAMPLE_W-1:0]          out_sample;
  logic [pts_pkg::STEP_OUT_W-1:0]        out_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count        <= pts_pkg::STEP_COUNT_RST;
      octave_shift      <= pts_pkg::SHIFT_RST;
      frames_per_beat   <= pts_pkg::FPB_RST;
      samples_per_frame <= pts_pkg::SPF_RST;
    end else if (cfg_we) begin
      case (pts_pkg::cfg_reg_t'(cfg_index))
        pts_pkg::REG_STEP_COUNT:
          step_count <= cfg_data[pts_pkg::STEP_CNT_W-1:0];
        pts_pkg::REG_OCTAVE_SHIFT:
          octave_shift <= cfg_data[pts_pkg::SHIFT_W-1:0];
        pts_pkg::REG_FRAMES_PER_BEAT:
          frames_per_beat <= cfg_data[pts_pkg::FPB_W-1:0];
        pts_pkg::REG_SAMPLES_PER_FRAME:
          samples_per_frame <= cfg_data[pts_pkg::SPF_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_step = in_data[pts_pkg::STEP_IN_W-1:0];
  assign ram_we  = cmd.load && (32'(in_step) < MAX_STEPS);

  pts_ram #(
    .WIDTH (pts_pkg::ROW_W),
    .DEPTH (MAX_STEPS)
  ) u_chord_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (STEP_W'(in_step)),
    .wdata (in_data[pts_pkg::STEP_IN_W +: pts_pkg::ROW_W]),
    .re    (cmd.tick_begin),
    .raddr (step_now),
    .rdata (row)
  );

  assign row_count = row[pts_pkg::COUNT_W-1:0];
  assign note_sel  = row[pts_pkg::COUNT_W + pts_pkg::NOTE_W * cmd.voice[1:0] +: pts_pkg::NOTE_W];

  assign eff    = (32'(step_count) > MAX_STEPS) ? pts_pkg::STEP_CNT_W'(MAX_STEPS) : step_count;
  assign active = running && (step_count != '0);

  assign status.active   = active;
  assign status.sounding = (row_count > pts_pkg::COUNT_W'(NV)) ? pts_pkg::COUNT_W'(NV)
                                                                : row_count;

  // Note to octave and pitch class.
  always_comb begin
    shift12  = 9'(octave_shift) * 9'sd12;
    note_sum = $signed({2'b00, note_sel}) + shift12;
    if (note_sum < 9'sd0) begin
      note_clamped = '0;
    end else if (note_sum > 9'sd127) begin
      note_clamped = 7'd127;
    end else begin
      note_clamped = note_sum[6:0];
    end
    oct_prod = 15'(note_clamped) * 15'd171;
    oct_val  = oct_prod[14:11];
    rem_val  = 4'(note_clamped - 7'(7'(oct_val) * 7'd12));
  end

  // Phase to folded quarter-wave argument.
  always_comb begin
    phase_sel = phase[cmd.voice[VW-1:0]];
    sine_idx  = phase_sel[PHASE_BITS-1 -: pts_pkg::SINE_BITS];
    turn      = 16'(sine_idx) << (16 - pts_pkg::SINE_BITS);
    x_val     = turn[14] ? 15'(15'd16384 - 15'(turn[13:0])) : 15'(turn[13:0]);
  end

  always_comb begin
    sq          = 30'(x) * 30'(x);
    inc_shifted = SW'(STEP_TABLE[rem]) << oct;
    inc_sum     = inc_shifted + (SW'(1) << 20);
    q_prod      = 26'(x2) * 26'(11'd1160);
    w_prod      = 29'(x2) * 29'(q);
    y_prod      = 30'(x) * 30'(w);
    y           = 16'(y_prod >> 14);
    two_y       = 17'(y) << 1;
    sine_ext    = quad[1] ? -$signed(19'(two_y)) : $signed(19'(two_y));
    abs_sum     = (sum < 19'sd0) ? 18'(-sum) : 18'(sum);
    quot        = quot_prod[pts_pkg::RECIP_SHIFT +: 18];
    quot_signed = neg ? 18'(-quot) : quot;
  end

  always_ff @(posedge clk) begin
    if (cmd.voice_setup) begin
      x    <= x_val;
      quad <= turn[15:14];
      oct  <= oct_val;
      rem  <= rem_val;
    end
    if (cmd.step_x2) begin
      x2  <= 15'(sq >> 14);
      inc <= inc_sum[21 +: PHASE_BITS];
    end
    if (cmd.step_q) begin
      q <= 14'(14'd10512 - 14'(q_prod >> 14));
    end
    if (cmd.step_w) begin
      w <= 15'(15'd25736 - 15'(w_prod >> 14));
    end
    if (cmd.tick_begin) begin
      sum <= '0;
    end else if (cmd.voice_finish) begin
      sum <= sum + sine_ext;
    end
    if (cmd.mix_abs) begin
      neg      <= sum < 19'sd0;
      mag_prod <= 33'(abs_sum) * 33'(15'd32767);
    end
    if (cmd.mix_div) begin
      quot_prod <= 42'(mag_prod[32:16]) * 42'(pts_pkg::RECIP[row_count]);
    end
  end

  assign spf_inc    = sample_in_frame + 1'b1;
  assign fpb_inc    = frame_in_beat + 1'b1;
  assign step_inc   = (STEP_W + 1)'(step_now) + 1'b1;
  assign frame_wrap = spf_inc == samples_per_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      sample_in_frame <= '0;
      frame_in_beat   <= '0;
      step_now        <= '0;
      for (int i = 0; i < NV; i++) begin
        phase[i] <= '0;
      end
    end else begin
      if (cmd.start) begin
        running         <= step_count != '0;
        sample_in_frame <= '0;
        frame_in_beat   <= '0;
        step_now        <= '0;
        for (int i = 0; i < NV; i++) begin
          phase[i] <= '0;
        end
      end
      if (cmd.stop) begin
        running <= 1'b0;
      end
      if (cmd.voice_finish) begin
        phase[cmd.voice[VW-1:0]] <= phase_sel + inc;
      end
      if (cmd.emit && active) begin
        if (frame_wrap) begin
          sample_in_frame <= '0;
          if (fpb_inc == frames_per_beat) begin
            frame_in_beat <= '0;
            if (32'(step_inc) >= 32'(eff)) begin
              step_now <= '0;
            end else begin
              step_now <= step_now + 1'b1;
            end
          end else begin
            frame_in_beat <= fpb_inc;
          end
        end else begin
          sample_in_frame <= spf_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample <= active ? quot_signed[pts_pkg::SAMPLE_W-1:0] : '0;
      out_step   <= pts_pkg::STEP_OUT_W'(step_now);
      out_last   <= active && frame_wrap;
    end
  end

  assign out_data = {{pts_pkg::OUT_PAD_W{1'b0}}, out_step, out_sample};

endmodule

FILE: design/polyphonic_tone_sequencer_top.sv
// ----------------------------------------------------------------------------
// Polyphonic tone sequencer
// Load, start and stop items return nothing. A sample tick returns one result:
// while playback is stopped it goes straight to the output, and while playing
// it runs the sine polynomial for each voice sounding in the current step, its
// four multiplies in turn for one voice after another, followed by the mixer,
// which takes the magnitude of the sum and then divides by the voice count.
// The block takes a new item only between items, but a finished result waiting
// in the output register does not hold off the next item. The chord memory is
// not cleared after reset; a step must be loaded before it is played.
// ----------------------------------------------------------------------------
module polyphonic_tone_sequencer_top #(
  parameter int unsigned MAX_STEPS  = 16,
  parameter int unsigned VOICES     = 4,
  parameter int unsigned PHASE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // step_index, voice_count, note_first, note_second, note_third, note_fourth
  input  logic [pts_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [pts_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sample, current_step
  output logic [pts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // frame_end
  output logic                              m_axis_tlast
);

  pts_pkg::cmd_t    cmd;
  pts_pkg::status_t status;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pts_datapath #(
    .MAX_STEPS  (MAX_STEPS),
    .VOICES     (VOICES),
    .PHASE_BITS (PHASE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: design/pts_checker.sv
// ----------------------------------------------------------------------------
// Tone sequencer checker
// Port-level checks of transfer timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pts_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [pts_pkg::OP_W-1:0]          s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [pts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic                              m_axis_tlast
);

  `PTS_ASSERT_NEXT(a_reset_clears_result, clk, 1'b0, rst, !m_axis_tvalid, "result valid after reset")
  `PTS_ASSERT_NEXT(a_result_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
  `PTS_ASSERT_NEXT(a_tick_busy, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == pts_pkg::OP_TICK), !s_axis_tready, "tick transfer did not occupy the block")
  `PTS_ASSERT_NEXT(a_control_item_quick, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser != pts_pkg::OP_TICK), s_axis_tready, "control transfer held off the next item")
  `PTS_ASSERT_NOW(a_result_after_work, clk, rst, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared without a tick in progress")

endmodule

bind polyphonic_tone_sequencer_top pts_checker u_pts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
